// ===== src/sim32_pkg.sv =====
// Shared types and constants for the Simon 32/64 block cipher.
// No dependencies; every other file in src imports this package.
package sim32_pkg;

  // Cipher geometry
  localparam int unsigned WordW    = 16;
  localparam int unsigned Rounds   = 32;
  localparam int unsigned RoundIdW = $clog2(Rounds);
  localparam int unsigned KeyWords = 4;
  localparam int unsigned CfgIdxW  = 3;

  typedef logic [WordW-1:0]    word_t;
  typedef logic [RoundIdW-1:0] round_idx_t;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;

  // Configuration register indexes
  localparam cfg_idx_t RegKeyWord0 = cfg_idx_t'(0);
  localparam cfg_idx_t RegKeyWord1 = cfg_idx_t'(1);
  localparam cfg_idx_t RegKeyWord2 = cfg_idx_t'(2);
  localparam cfg_idx_t RegKeyWord3 = cfg_idx_t'(3);

  // Key schedule constants: z0 sequence bits 0..31 and the fixed c value.
  localparam logic [Rounds-1:0] Z0Seq    = 32'hB386_A45F;
  localparam word_t             KeyConst = 16'hFFFC;

endpackage

// ===== src/sim32_if.sv =====
// Handshake channels of the Simon 32/64 block cipher: input, result and
// configuration write. Depends on sim32_pkg.

interface sim32_in_if;
  import sim32_pkg::*;
  logic  valid;
  logic  ready;
  logic  action;
  word_t block_x;
  word_t block_y;
  modport source (output valid, output action, output block_x, output block_y, input ready);
  modport sink   (input valid, input action, input block_x, input block_y, output ready);
endinterface

interface sim32_out_if;
  import sim32_pkg::*;
  logic  valid;
  logic  ready;
  word_t out_x;
  word_t out_y;
  modport source (output valid, output out_x, output out_y, input ready);
  modport sink   (input valid, input out_x, input out_y, output ready);
endinterface

interface sim32_cfg_if;
  import sim32_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  word_t    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/simon32_64_block_cipher.sv =====
// Simon 32/64 block cipher top level: key registers, word-serial key
// schedule, round key memory and a shared round unit. Depends on sim32_pkg
// and the channel interfaces in sim32_if.sv.
// A result passes through the round unit, one round at a time, then through
// the hand-over state into the output register, which waits for it to be free.
// A new item is taken only once the last one has been handed over; the
// single round unit with its one key memory read per cycle sets this limit.
// Reset clears the key words to zero and marks the round keys stale. The key
// expansion then writes one round key a cycle into the memory, and is rerun after
// any key write; no item is accepted until it has finished.
module simon32_64_block_cipher (
  input  logic               clk_i,
  input  logic               rst_ni,
  sim32_in_if.sink           in_i,
  sim32_out_if.source        out_o,
  sim32_cfg_if.sink          cfg_i
);
  import sim32_pkg::*;

  // Controller state codes
  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StExpand = 2'd1;
  localparam logic [1:0] StRound  = 2'd2;
  localparam logic [1:0] StDone   = 2'd3;

  localparam round_idx_t LastIdx = round_idx_t'(Rounds - 1);

  function automatic word_t rotl(input word_t v, input int unsigned s);
    rotl = word_t'((v << s) | (v >> (WordW - s)));
  endfunction

  function automatic word_t rotr(input word_t v, input int unsigned s);
    rotr = word_t'((v >> s) | (v << (WordW - s)));
  endfunction

  // Simon round function f(v) = (v <<< 1 & v <<< 8) ^ v <<< 2
  function automatic word_t round_f(input word_t v);
    round_f = (rotl(v, 1) & rotl(v, 8)) ^ rotl(v, 2);
  endfunction

  logic [1:0] state_q, state_d;
  round_idx_t cnt_q, cnt_d;
  logic       keys_ready_q, keys_ready_d;
  logic       op_q, op_d;
  word_t      key_q [KeyWords];
  word_t      ks_q [KeyWords];
  word_t      ks_d [KeyWords];
  word_t      a_q, a_d, b_q, b_d;
  word_t      rkey_q;
  word_t      round_keys [Rounds];
  logic       out_valid_q, out_valid_d;
  word_t      out_x_q, out_x_d, out_y_q, out_y_d;

  logic       in_acc, cfg_acc, key_wr, out_acc, out_free;
  logic       rd_dec;
  round_idx_t rd_seq, rd_addr;
  word_t      ks_t, ks_new;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid & cfg_i.ready;
  // Indexes beyond the last key word are accepted and dropped.
  assign key_wr      = cfg_acc & (cfg_i.index <= RegKeyWord3);

  assign in_i.ready  = (state_q == StIdle) & keys_ready_q;
  assign in_acc      = in_i.valid & in_i.ready;

  assign out_o.valid = out_valid_q;
  assign out_o.out_x = out_x_q;
  assign out_o.out_y = out_y_q;
  assign out_acc     = out_valid_q & out_o.ready;
  assign out_free    = ~out_valid_q | out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KeyWords; i++) begin
        key_q[i] <= '0;
      end
    end else if (key_wr) begin
      key_q[cfg_i.index[$clog2(KeyWords)-1:0]] <= cfg_i.data;
    end
  end

  // Key schedule step: the shift line holds k[i-4] .. k[i-1], oldest first.
  // The oldest word is written to the memory while k[i] enters at the far end.
  always_comb begin
    ks_t   = rotr(ks_q[3], 3) ^ ks_q[1];
    ks_new = ks_q[0] ^ ks_t ^ rotr(ks_t, 1) ^ KeyConst ^ word_t'(Z0Seq[cnt_q]);
  end

  // Round key read address. Encryption walks the keys upwards, decryption
  // downwards, which is the bitwise complement of the round number. The
  // first key is fetched in the accept cycle, each later one a round ahead.
  always_comb begin
    rd_seq  = (state_q == StIdle) ? '0 : round_idx_t'(cnt_q + 1'b1);
    rd_dec  = (state_q == StIdle) ? in_i.action : op_q;
    rd_addr = rd_dec ? ~rd_seq : rd_seq;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StExpand) begin
      round_keys[cnt_q] <= ks_q[0];
    end
    rkey_q <= round_keys[rd_addr];
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    keys_ready_d = keys_ready_q;
    op_d         = op_q;
    a_d          = a_q;
    b_d          = b_q;
    ks_d         = ks_q;
    out_valid_d  = out_valid_q & ~out_acc;
    out_x_d      = out_x_q;
    out_y_d      = out_y_q;

    unique case (state_q)
      StIdle: begin
        cnt_d = '0;
        if (in_acc) begin
          // Decryption runs through the same datapath with the halves
          // swapped on entry and again on exit.
          op_d    = in_i.action;
          a_d     = in_i.action ? in_i.block_y : in_i.block_x;
          b_d     = in_i.action ? in_i.block_x : in_i.block_y;
          state_d = StRound;
        end else if (!keys_ready_q && !key_wr) begin
          ks_d    = key_q;
          state_d = StExpand;
        end
      end
      StExpand: begin
        ks_d[0] = ks_q[1];
        ks_d[1] = ks_q[2];
        ks_d[2] = ks_q[3];
        ks_d[3] = ks_new;
        cnt_d   = round_idx_t'(cnt_q + 1'b1);
        if (key_wr) begin
          // A new key word makes this pass worthless: start again.
          state_d = StIdle;
        end else if (cnt_q == LastIdx) begin
          keys_ready_d = 1'b1;
          state_d      = StIdle;
        end
      end
      StRound: begin
        a_d   = b_q ^ round_f(a_q) ^ rkey_q;
        b_d   = a_q;
        cnt_d = round_idx_t'(cnt_q + 1'b1);
        if (cnt_q == LastIdx) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_x_d     = op_q ? b_q : a_q;
          out_y_d     = op_q ? a_q : b_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (key_wr) begin
      keys_ready_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cnt_q        <= '0;
      keys_ready_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      keys_ready_q <= keys_ready_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    a_q     <= a_d;
    b_q     <= b_d;
    ks_q    <= ks_d;
    out_x_q <= out_x_d;
    out_y_q <= out_y_d;
  end

  // An item is only taken once a full set of round keys is in the memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> keys_ready_q)
    else $error("item accepted without expanded round keys");

  // The last round always hands over to the output stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound && cnt_q == LastIdx) |=> state_q == StDone)
    else $error("round sequence did not finish after the last round");

  // A result only appears straight after the hand-over stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StDone))
    else $error("result became valid outside the hand-over stage");

  // Any key write leaves the round keys stale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_wr |=> !keys_ready_q)
    else $error("key write did not invalidate the round keys");

  // The result register is never overwritten while it still waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_x_q) && $stable(out_y_q)))
    else $error("waiting result was overwritten");

endmodule
